// ===== rtl/core/length_prefixed_frame_ring_queue_defines.svh =====
// ---------------------------------------------------------------------------
// Length-prefixed frame ring queue: assertion macros
// Shared concurrent assertion forms for the queue checker.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RING_QUEUE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RING_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPFRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lpfrq_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame ring queue package
// Item function codes, status codes and fixed limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfrq_pkg;

	typedef enum logic [1:0] {
		FUNC_BEGIN  = 2'd0,
		FUNC_BODY   = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_FINISH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_SEQUENCE = 2'd2
	} status_t;

	// Largest body length; longer frame lengths are capped to it.
	localparam logic [7:0] MAX_LEN = 8'd254;

	// Saturation value of the reported record count.
	localparam logic [9:0] COUNT_MAX = 10'd1023;

endpackage

// ===== rtl/core/length_prefixed_frame_ring_queue.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame ring queue
// Ring of variable-length records in a byte store, one-byte length header.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   begin frame (frame_length), body byte (frame_byte), read next byte of
//   the head record, or finish send (send_ok removes or rewinds the head).
//   Output channel (out_valid/out_ready) returns exactly one result per
//   command: read byte, record_last, queue_empty, status, record_count.
// Timing:
//   Result is registered; one command per cycle sustained when not
//   stalled. All state updates in the accept cycle; the body byte comes
//   from memory port B, the head header is prefetched on port A.
// Stall:
//   A single result register sits between the channels. in_ready is high
//   when it is empty or being drained, so a stalled receiver holds one
//   result and in_ready stays low until that result is taken.
// Reset:
//   Pointers, cursor and counts clear, queue is empty. Byte store contents
//   are not cleared and need no clearing pass.
// Ring wrap marker is kept in a position register rather than in the store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_ring_queue #(
	parameter int BUFFER_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  frame_length,
	input  logic [7:0]  frame_byte,
	input  logic        send_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        record_last,
	output logic        queue_empty,
	output logic [1:0]  status,
	output logic [9:0]  record_count
);

	localparam int PW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int SW = PW + 1;
	localparam int RW = (CW > 10) ? CW : 10;

	// control state
	logic [PW-1:0] wp_q, wp_d;
	logic [PW-1:0] rp_q, rp_d;
	logic [7:0]    cursor_q, cursor_d;
	logic [7:0]    body_rem_q, body_rem_d;
	logic [CW-1:0] records_q, records_d;
	logic          mark_vld_q, mark_vld_d;
	logic [PW-1:0] mark_pos_q, mark_pos_d;
	logic          mark_set;

	// result register
	logic          valid_s1;
	logic          byte_valid_s1;
	logic          record_last_s1;
	logic          queue_empty_s1;
	logic [1:0]    status_s1;
	logic [9:0]    record_count_s1;

	// result of the current item
	logic          res_byte_valid;
	logic          res_last;
	logic [1:0]    res_status;
	logic [9:0]    res_count;
	logic [RW-1:0] rec_w;

	// memory ports
	logic          we;
	logic [PW-1:0] wa;
	logic [7:0]    wd;
	logic [PW-1:0] hdr_addr_d;
	logic [7:0]    hdr_len;
	logic          rdb_en;
	logic [PW-1:0] rdb_addr;
	logic [7:0]    rdb_data;

	logic          accept;
	logic          mark_hit;
	logic [PW-1:0] eff_rp;
	logic [7:0]    len_cap;
	logic [SW-1:0] n_w;
	logic [SW-1:0] sum_w;
	logic          wrap;
	logic          ovf;
	logic [PW-1:0] head_addr;
	logic [PW-1:0] wp_inc;
	logic [SW-1:0] adv_w;
	logic [PW-1:0] rp_fin;
	logic [7:0]    cursor_inc;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// reader sees the marker position as a jump to the start of the store
	assign mark_hit = mark_vld_q && (rp_q == mark_pos_q);
	assign eff_rp   = mark_hit ? '0 : rp_q;

	assign len_cap = (frame_length > lpfrq_pkg::MAX_LEN) ? lpfrq_pkg::MAX_LEN : frame_length;
	assign n_w     = SW'(len_cap) + SW'(1);
	assign sum_w   = SW'(wp_q) + n_w;
	assign wrap    = sum_w > SW'(BUFFER_BYTES - 1);
	assign ovf     = (records_q != '0) &&
		((rp_q == wp_q) ||
		 ((rp_q > wp_q) && (wrap || (sum_w > SW'(rp_q)))) ||
		 ((rp_q < wp_q) && wrap && (n_w > SW'(rp_q))));
	assign head_addr = wrap ? '0 : wp_q;

	assign wp_inc     = (wp_q == PW'(BUFFER_BYTES - 1)) ? '0 : wp_q + PW'(1);
	assign adv_w      = SW'(eff_rp) + SW'(hdr_len) + SW'(1);
	assign rp_fin     = (adv_w >= SW'(BUFFER_BYTES - 1)) ? '0 : adv_w[PW-1:0];
	assign cursor_inc = cursor_q + 8'd1;

	always_comb begin
		wp_d           = wp_q;
		rp_d           = rp_q;
		cursor_d       = cursor_q;
		body_rem_d     = body_rem_q;
		records_d      = records_q;
		mark_vld_d     = mark_vld_q;
		mark_pos_d     = mark_pos_q;
		mark_set       = 1'b0;
		we             = 1'b0;
		wa             = wp_q;
		wd             = frame_byte;
		rdb_en         = 1'b0;
		rdb_addr       = eff_rp + PW'(cursor_q) + PW'(1);
		res_byte_valid = 1'b0;
		res_last       = 1'b0;
		res_status     = lpfrq_pkg::STATUS_OK;

		if (accept) begin
			unique case (lpfrq_pkg::func_t'(func))
				lpfrq_pkg::FUNC_BEGIN: begin
					if (body_rem_q != 8'd0) begin
						res_status = lpfrq_pkg::STATUS_SEQUENCE;
					end else begin
						if (records_q == '0) begin
							rp_d = wp_q;
						end
						if (ovf) begin
							res_status = lpfrq_pkg::STATUS_OVERFLOW;
						end else begin
							if (wrap) begin
								mark_set   = 1'b1;
								mark_vld_d = 1'b1;
								mark_pos_d = wp_q;
							end
							we         = 1'b1;
							wa         = head_addr;
							wd         = len_cap;
							wp_d       = head_addr + PW'(1);
							body_rem_d = len_cap;
							if (len_cap == 8'd0) begin
								records_d = records_q + CW'(1);
							end
						end
					end
				end
				lpfrq_pkg::FUNC_BODY: begin
					if (body_rem_q == 8'd0) begin
						res_status = lpfrq_pkg::STATUS_SEQUENCE;
					end else begin
						we         = 1'b1;
						wa         = wp_q;
						wd         = frame_byte;
						wp_d       = wp_inc;
						body_rem_d = body_rem_q - 8'd1;
						if (body_rem_q == 8'd1) begin
							records_d = records_q + CW'(1);
						end
					end
				end
				lpfrq_pkg::FUNC_READ: begin
					if (records_q != '0) begin
						if (mark_hit) begin
							mark_vld_d = 1'b0;
							rp_d       = '0;
						end
						if (cursor_q >= hdr_len) begin
							res_last = 1'b1;
						end else begin
							rdb_en         = 1'b1;
							res_byte_valid = 1'b1;
							cursor_d       = cursor_inc;
							res_last       = (cursor_inc == hdr_len);
						end
					end
				end
				lpfrq_pkg::FUNC_FINISH: begin
					if (records_q == '0) begin
						res_status = lpfrq_pkg::STATUS_SEQUENCE;
					end else begin
						cursor_d = 8'd0;
						if (send_ok) begin
							if (mark_hit) begin
								mark_vld_d = 1'b0;
							end
							rp_d      = rp_fin;
							records_d = records_q - CW'(1);
						end
					end
				end
			endcase
		end

		// a store write over the live marker overwrites it
		if (we && !mark_set && mark_vld_q && (wa == mark_pos_q)) begin
			mark_vld_d = 1'b0;
		end
	end

	// prefetch the head header for the state after this cycle
	assign hdr_addr_d = (mark_vld_d && (rp_d == mark_pos_d)) ? '0 : rp_d;

	assign rec_w     = RW'(records_d);
	assign res_count = (rec_w > RW'(lpfrq_pkg::COUNT_MAX)) ? lpfrq_pkg::COUNT_MAX : rec_w[9:0];

	lpfrq_ram #(
		.DEPTH (BUFFER_BYTES),
		.AW    (PW)
	) u_ram (
		.clk      (clk),
		.wr_en    (we),
		.wr_addr  (wa),
		.wr_data  (wd),
		.rda_addr (hdr_addr_d),
		.rda_data (hdr_len),
		.rdb_en   (rdb_en),
		.rdb_addr (rdb_addr),
		.rdb_data (rdb_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			cursor_q   <= '0;
			body_rem_q <= '0;
			records_q  <= '0;
			mark_vld_q <= 1'b0;
			mark_pos_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			wp_q       <= wp_d;
			rp_q       <= rp_d;
			cursor_q   <= cursor_d;
			body_rem_q <= body_rem_d;
			records_q  <= records_d;
			mark_vld_q <= mark_vld_d;
			mark_pos_q <= mark_pos_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_valid_s1   <= res_byte_valid;
			record_last_s1  <= res_last;
			queue_empty_s1  <= (records_d == '0);
			status_s1       <= res_status;
			record_count_s1 <= res_count;
		end
	end

	assign out_valid    = valid_s1;
	assign out_byte     = byte_valid_s1 ? rdb_data : 8'd0;
	assign byte_valid   = byte_valid_s1;
	assign record_last  = record_last_s1;
	assign queue_empty  = queue_empty_s1;
	assign status       = status_s1;
	assign record_count = record_count_s1;

endmodule

// ===== rtl/core/lpfrq_ram.sv =====
// ---------------------------------------------------------------------------
// Frame ring queue byte store
// One write port, two registered read ports. Port A reads every cycle and
// forwards a same-cycle write to its address; port B reads on enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfrq_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rda_addr,
	output logic [7:0]    rda_data,
	input  logic          rdb_en,
	input  logic [AW-1:0] rdb_addr,
	output logic [7:0]    rdb_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rda_q;
	logic [7:0] byp_data_q;
	logic       byp_q;
	logic [7:0] rdb_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rda_q      <= mem[rda_addr];
		byp_q      <= wr_en && (wr_addr == rda_addr);
		byp_data_q <= wr_data;
		if (rdb_en) begin
			rdb_q <= mem[rdb_addr];
		end
	end

	assign rda_data = byp_q ? byp_data_q : rda_q;
	assign rdb_data = rdb_q;

endmodule

// ===== rtl/core/lpfrq_checker.sv =====
// ---------------------------------------------------------------------------
// Frame ring queue port checker
// Port-level properties of the queue, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_frame_ring_queue_defines.svh"

module lpfrq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       record_last,
	input logic       queue_empty,
	input logic [1:0] status,
	input logic [9:0] record_count
);

	// held result must not change under back-pressure
	`LPFRQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(record_last) && $stable(status) && $stable(record_count), "result changed while stalled")

	`LPFRQ_ASSERT_IMP(a_empty_count, clk, arst_n, out_valid, queue_empty == (record_count == 10'd0), "queue_empty disagrees with record_count")

	// a streamed byte comes only from a held record
	`LPFRQ_ASSERT_IMP(a_byte_held, clk, arst_n, out_valid && byte_valid, !queue_empty && (status == lpfrq_pkg::STATUS_OK), "byte returned from empty queue")

	// empty result register always takes a transfer
	`LPFRQ_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready, "input blocked with no pending result")

	// every input transfer leaves a result behind
	`LPFRQ_ASSERT_NXT(a_accept_result, clk, arst_n, in_valid && in_ready, out_valid, "input transfer produced no result")

endmodule

bind length_prefixed_frame_ring_queue lpfrq_checker u_lpfrq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.byte_valid   (byte_valid),
	.record_last  (record_last),
	.queue_empty  (queue_empty),
	.status       (status),
	.record_count (record_count)
);
